FILE: hdl/bcpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bcpa_pkg;

  localparam int EW        = 63;              // coordinate / coefficient width
  localparam int PW        = 64;              // polynomial register width
  localparam int OPC_W     = 2;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = $clog2(EW + 1);

  localparam int S_TDATA_W = 256;
  localparam int S_TUSER_W = 4;
  localparam int M_TDATA_W = 128;
  localparam int M_TUSER_W = 3;

  localparam logic [OPC_W-1:0] OPC_ADD = 2'd0;
  localparam logic [OPC_W-1:0] OPC_SUB = 2'd1;
  localparam logic [OPC_W-1:0] OPC_NEG = 2'd2;

  localparam logic [ST_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [ST_W-1:0] STATUS_BAD_IN  = 2'd1;
  localparam logic [ST_W-1:0] STATUS_BAD_OUT = 2'd2;
  localparam logic [ST_W-1:0] STATUS_UNUSED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_POLY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B    = 2'd2;

  localparam logic [PW-1:0] POLY_RESET = 64'h8000_0000_0000_0003;

  typedef logic [EW-1:0] elem_t;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    elem_t            fx;
    elem_t            fy;
    logic             finf;
    elem_t            sx;
    elem_t            sy;
    logic             sinf;
  } item_t;

  typedef struct packed {
    elem_t           x;
    elem_t           y;
    logic            inf;
    logic [ST_W-1:0] status;
  } res_t;

  typedef struct packed {
    logic start;
    logic long_run;   // run over all EW bits of b (reduction) instead of the field width
  } mul_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/bcpa_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module bcpa_cell (
  input  wire  clk,
  input  wire  clr,
  input  wire  run,
  input  wire  en,      // bit lies below the field degree
  input  wire  prev,    // neighbor bit one place down
  input  wire  top,     // bit m-1 of the row, fed back for reduction
  input  wire  bbit,    // current multiplier bit
  input  wire  a_bit,
  input  wire  p_bit,
  output logic r
);

  always_ff @(posedge clk) begin
    if (clr) begin
      r <= 1'b0;
    end else if (run) begin
      r <= en & (prev ^ (top & p_bit) ^ (bbit & a_bit));
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bcpa_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module bcpa_mul #(
  parameter int N = 63
) (
  input  wire                 clk,
  input  wire                 rst,
  input  bcpa_pkg::mul_ctl_t  ctl,
  input  wire [N-1:0]         a,
  input  wire [bcpa_pkg::EW-1:0] b,
  input  wire [N-1:0]         pmask,
  input  wire [N-1:0]         mmask,
  input  wire [N-1:0]         mtop,
  output logic                done,
  output logic [N-1:0]        prod
);
  import bcpa_pkg::*;

  logic             run;
  logic [CNT_W-1:0] cnt;
  elem_t            bsh;
  logic             top;

  // MSB-first shift-and-add: r = r*x mod p ^ (b_i ? a : 0)
  assign top = |(prod & mtop);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == CNT_W'(1));
      if (ctl.start) begin
        run <= 1'b1;
      end else if (run && (cnt == CNT_W'(1))) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      bsh <= ctl.long_run ? b : (b << (EW - N));
      cnt <= ctl.long_run ? CNT_W'(EW) : CNT_W'(N);
    end else if (run) begin
      bsh <= bsh << 1;
      cnt <= cnt - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    bcpa_cell u_cell (
      .clk   (clk),
      .clr   (ctl.start),
      .run   (run),
      .en    (mmask[i]),
      .prev  ((i == 0) ? 1'b0 : prod[(i == 0) ? 0 : i - 1]),
      .top   (top),
      .bbit  (bsh[EW-1]),
      .a_bit (a[i]),
      .p_bit (pmask[i]),
      .r     (prod[i])
    );
  end

endmodule
`default_nettype wire

FILE: hdl/bcpa_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module bcpa_seq #(
  parameter int N = 63
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire [bcpa_pkg::PW-1:0] poly,
  input  wire [bcpa_pkg::EW-1:0] ca_raw,
  input  wire [bcpa_pkg::EW-1:0] cb_raw,
  input  bcpa_pkg::item_t        item,
  input  wire                    item_valid,
  output logic                   item_take,
  output bcpa_pkg::res_t         res,
  output logic                   res_valid,
  input  wire                    res_ready
);
  import bcpa_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RED    = 4'd1;
  localparam logic [3:0] S_PLAN   = 4'd2;
  localparam logic [3:0] S_ADD    = 4'd3;
  localparam logic [3:0] S_C0     = 4'd4;
  localparam logic [3:0] S_C1     = 4'd5;
  localparam logic [3:0] S_C2     = 4'd6;
  localparam logic [3:0] S_C3     = 4'd7;
  localparam logic [3:0] S_C4     = 4'd8;
  localparam logic [3:0] S_CRET   = 4'd9;
  localparam logic [3:0] S_INV_SQ = 4'd10;
  localparam logic [3:0] S_INV_MU = 4'd11;
  localparam logic [3:0] S_LAM    = 4'd12;
  localparam logic [3:0] S_RX     = 4'd13;
  localparam logic [3:0] S_RY     = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  localparam logic [2:0] RET_NEG  = 3'd0;
  localparam logic [2:0] RET_SUBQ = 3'd1;
  localparam logic [2:0] RET_P    = 3'd2;
  localparam logic [2:0] RET_Q    = 3'd3;
  localparam logic [2:0] RET_R    = 3'd4;

  localparam logic [1:0] SEL_P = 2'd0;
  localparam logic [1:0] SEL_Q = 2'd1;
  localparam logic [1:0] SEL_R = 2'd2;

  logic [3:0]       state;
  logic             waitm;
  logic [2:0]       k;
  logic [OPC_W-1:0] op;
  logic             pi, qi;
  elem_t            px, py, qx, qy, ca, cb;
  logic [N-1:0]     xx, acc, lhs, t, ir, itm, lam, rx, ry;
  logic [1:0]       chk_sel;
  logic [2:0]       ret;
  logic             dbl, chk_ok;

  logic [N-1:0]     mmask, mtop, pmask;
  logic [N:0]       pv;
  logic [N-1:0]     mmask_c;

  mul_ctl_t         mctl;
  logic [N-1:0]     ma, prod;
  elem_t            mb;
  logic             mdone;
  logic             mul_state;
  logic [N-1:0]     cx, cy, d;
  logic             cz;

  // field degree masks, taken from the polynomial register
  assign pv = poly[N:0];
  for (genvar i = 0; i < N; i++) begin : g_mask
    assign mmask_c[i] = |(pv >> (i + 1));
  end

  always_ff @(posedge clk) begin
    mmask <= mmask_c;
    mtop  <= mmask_c & ~(mmask_c >> 1);
    pmask <= pv[N-1:0] & mmask_c;
  end

  always_comb begin
    unique case (chk_sel)
      SEL_P:   begin cx = px[N-1:0]; cy = py[N-1:0]; end
      SEL_Q:   begin cx = qx[N-1:0]; cy = qy[N-1:0]; end
      default: begin cx = rx;        cy = ry;        end
    endcase
  end
  assign cz = (cx == '0) && (cy == '0);

  assign mul_state = (state != S_IDLE) && (state != S_PLAN) && (state != S_ADD) &&
                     (state != S_CRET) && (state != S_DONE);

  always_comb begin
    ma = '0;
    mb = '0;
    mctl.long_run = 1'b0;
    unique case (state)
      S_RED: begin
        ma = N'(1);
        mctl.long_run = 1'b1;
        unique case (k)
          3'd0:    mb = px;
          3'd1:    mb = py;
          3'd2:    mb = qx;
          3'd3:    mb = qy;
          3'd4:    mb = ca;
          default: mb = cb;
        endcase
      end
      S_C0:     begin ma = cx;  mb = EW'(cx); end
      S_C1:     begin ma = xx;  mb = EW'(cx); end
      S_C2:     begin ma = ca[N-1:0]; mb = EW'(xx); end
      S_C3:     begin ma = cy;  mb = EW'(cy); end
      S_C4:     begin ma = cx;  mb = EW'(cy); end
      S_INV_SQ: begin ma = t;   mb = EW'(t); end
      S_INV_MU: begin ma = ir;  mb = EW'(t); end
      S_LAM: begin
        ma = dbl ? py[N-1:0] : (qy[N-1:0] ^ py[N-1:0]);
        mb = EW'(ir);
      end
      S_RX:     begin ma = lam; mb = EW'(lam); end
      S_RY:     begin ma = lam; mb = EW'(px[N-1:0] ^ rx); end
      default:  begin ma = '0;  mb = '0; end
    endcase
    mctl.start = mul_state && !waitm && !((state == S_C0) && cz);
  end

  bcpa_mul #(.N(N)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mctl),
    .a     (ma),
    .b     (mb),
    .pmask (pmask),
    .mmask (mmask),
    .mtop  (mtop),
    .done  (mdone),
    .prod  (prod)
  );

  assign item_take = (state == S_IDLE) && item_valid;
  assign res_valid = (state == S_DONE);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      waitm <= 1'b0;
    end else begin
      if (mctl.start) begin
        waitm <= 1'b1;
      end else if (mdone) begin
        waitm <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (item_valid) state <= S_RED;
        S_RED:  if (mdone && (k == 3'd5)) state <= S_PLAN;
        S_PLAN: begin
          priority if (op == OPC_NEG) begin
            state <= pi ? S_DONE : S_C0;
          end else if ((op == OPC_SUB) && !qi) begin
            state <= S_C0;
          end else begin
            state <= S_ADD;
          end
        end
        S_ADD:  state <= (pi || qi) ? S_DONE : S_C0;
        S_C0: begin
          priority if (!waitm && cz) state <= S_CRET;
          else if (mdone) state <= S_C1;
        end
        S_C1:   if (mdone) state <= S_C2;
        S_C2:   if (mdone) state <= S_C3;
        S_C3:   if (mdone) state <= S_C4;
        S_C4:   if (mdone) state <= S_CRET;
        S_CRET: begin
          priority if (!chk_ok || (ret == RET_NEG) || (ret == RET_R)) begin
            state <= S_DONE;
          end else if (ret == RET_SUBQ) begin
            state <= S_ADD;
          end else if (ret == RET_P) begin
            state <= S_C0;
          end else if ((px == qx) && ((py == (qx ^ qy)) ||
                       ((py == qy) && (px == '0)))) begin
            state <= S_DONE;
          end else if ((d == '0) || ((mmask >> 1) == '0)) begin
            state <= S_LAM;
          end else begin
            state <= S_INV_SQ;
          end
        end
        S_INV_SQ: if (mdone) state <= S_INV_MU;
        S_INV_MU: if (mdone) state <= ((itm >> 1) == '0) ? S_LAM : S_INV_SQ;
        S_LAM:  if (mdone) state <= S_RX;
        S_RX:   if (mdone) state <= S_RY;
        S_RY:   if (mdone) state <= S_C0;
        S_DONE: if (res_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // divisor for the slope: x1 when doubling, x1 + x2 otherwise
  assign d = (py == qy && px == qx) ? px[N-1:0] : (px[N-1:0] ^ qx[N-1:0]);

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op <= item.opcode;
        pi <= item.finf;
        qi <= item.sinf;
        px <= item.fx;
        py <= item.fy;
        qx <= item.sx;
        qy <= item.sy;
        ca <= ca_raw;
        cb <= cb_raw;
        k  <= 3'd0;
      end
      S_RED: begin
        if (mdone) begin
          unique case (k)
            3'd0:    px <= EW'(prod);
            3'd1:    py <= EW'(prod);
            3'd2:    qx <= EW'(prod);
            3'd3:    qy <= EW'(prod);
            3'd4:    ca <= EW'(prod);
            default: cb <= EW'(prod);
          endcase
          k <= k + 3'd1;
        end
      end
      S_PLAN: begin
        priority if (op == OPC_NEG) begin
          res <= '{x: '0, y: '0, inf: 1'b1, status: STATUS_OK};
          chk_sel <= SEL_P;
          ret <= RET_NEG;
        end else begin
          chk_sel <= SEL_Q;
          ret <= RET_SUBQ;
        end
      end
      S_ADD: begin
        priority if (pi) begin
          res <= '{x: qi ? '0 : qx, y: qi ? '0 : qy, inf: qi, status: STATUS_OK};
        end else begin
          res <= '{x: px, y: py, inf: 1'b0, status: STATUS_OK};
        end
        chk_sel <= SEL_P;
        ret <= RET_P;
      end
      S_C0: begin
        if (!waitm && cz) chk_ok <= 1'b1;
        if (mdone) xx <= prod;
      end
      S_C1: if (mdone) acc <= prod;
      S_C2: if (mdone) acc <= acc ^ prod;
      S_C3: if (mdone) lhs <= prod;
      S_C4: if (mdone) chk_ok <= ((acc ^ cb[N-1:0]) == (lhs ^ prod));
      S_CRET: begin
        priority if (ret == RET_R) begin
          // computed point goes out even when it fails the curve check
          res <= '{x: EW'(rx), y: EW'(ry), inf: 1'b0,
                   status: chk_ok ? STATUS_OK : STATUS_BAD_OUT};
        end else if (!chk_ok) begin
          res <= '{x: '0, y: '0, inf: 1'b0, status: STATUS_BAD_IN};
        end else if (ret == RET_NEG) begin
          res <= '{x: px, y: px ^ py, inf: 1'b0, status: STATUS_OK};
        end else if (ret == RET_SUBQ) begin
          qy <= qx ^ qy;
        end else if (ret == RET_P) begin
          chk_sel <= SEL_Q;
          ret <= RET_Q;
        end else begin
          // opposite points or doubling at x = 0 give infinity
          res <= '{x: '0, y: '0, inf: 1'b1, status: STATUS_OK};
          dbl <= (px == qx) && (py == qy);
          t   <= d;
          ir  <= (d == '0) ? '0 : N'(1);
          itm <= mmask >> 1;
        end
      end
      S_INV_SQ: if (mdone) t <= prod;
      S_INV_MU: begin
        if (mdone) begin
          ir  <= prod;
          itm <= itm >> 1;
        end
      end
      S_LAM: if (mdone) lam <= dbl ? (px[N-1:0] ^ prod) : prod;
      S_RX: begin
        if (mdone) begin
          rx <= prod ^ lam ^ ca[N-1:0] ^ (dbl ? '0 : (px[N-1:0] ^ qx[N-1:0]));
        end
      end
      S_RY: begin
        if (mdone) begin
          ry      <= prod ^ rx ^ py[N-1:0];
          chk_sel <= SEL_R;
          ret     <= RET_R;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/binary_curve_point_add.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake              Payload
// s        in   s_tvalid / s_tready    s_tdata: two points, s_tuser: opcode + inf flags
// m        out  m_tvalid / m_tready    m_tdata: result point, m_tuser: inf + status
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data (ready always high)
//
// Each item runs six reductions, then multiplications on one row of N shift-and-add
// cells; the inversion chain sets the run time.
// A one-beat input buffer takes the next item while one is at work, and the output
// register holds a finished result until taken. Reset is synchronous and clears
// control state and the curve registers to x^63 + x + 1, a = 0, b = 1.
module binary_curve_point_add #(
  parameter int FIELD_BITS = 63
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  // x1[62:0], y1[125:63], x2[188:126], y2[251:189], zero fill
  input  wire [bcpa_pkg::S_TDATA_W-1:0]     s_tdata,
  // opcode[1:0], first_inf[2], second_inf[3]
  input  wire [bcpa_pkg::S_TUSER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // result_x[62:0], result_y[125:63], zero fill
  output logic [bcpa_pkg::M_TDATA_W-1:0]    m_tdata,
  // result_inf[0], status[2:1]
  output logic [bcpa_pkg::M_TUSER_W-1:0]    m_tuser,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [bcpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [bcpa_pkg::PW-1:0]            cfg_data
);
  import bcpa_pkg::*;

  logic [PW-1:0] poly;
  elem_t         ca, cb;
  item_t         ibuf;
  logic          ibuf_valid;
  logic          take;
  res_t          res, ores;
  logic          res_valid, res_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= POLY_RESET;
      ca   <= '0;
      cb   <= EW'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_POLY: poly <= cfg_data;
        CFG_A:    ca   <= cfg_data[EW-1:0];
        CFG_B:    cb   <= cfg_data[EW-1:0];
        default: begin
        end
      endcase
    end
  end

  // input buffer beat
  assign s_tready = !ibuf_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ibuf_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      ibuf_valid <= 1'b1;
    end else if (take) begin
      ibuf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ibuf <= '{opcode: s_tuser[OPC_W-1:0],
                fx:     s_tdata[EW-1:0],
                fy:     s_tdata[2*EW-1:EW],
                finf:   s_tuser[OPC_W],
                sx:     s_tdata[3*EW-1:2*EW],
                sy:     s_tdata[4*EW-1:3*EW],
                sinf:   s_tuser[OPC_W+1]};
    end
  end

  bcpa_seq #(.N(FIELD_BITS)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .poly       (poly),
    .ca_raw     (ca),
    .cb_raw     (cb),
    .item       (ibuf),
    .item_valid (ibuf_valid),
    .item_take  (take),
    .res        (res),
    .res_valid  (res_valid),
    .res_ready  (res_ready)
  );

  // output register beat
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      ores <= res;
    end
  end

  assign m_tdata = {{(M_TDATA_W - 2*EW){1'b0}}, ores.y, ores.x};
  assign m_tuser = {ores.status, ores.inf};

endmodule
`default_nettype wire

FILE: hdl/bcpa_check.sv
`timescale 1ns / 1ps
`default_nettype none
module bcpa_check (
  input wire                            clk,
  input wire                            rst,
  input wire                            m_tvalid,
  input wire                            m_tready,
  input wire [bcpa_pkg::M_TDATA_W-1:0]  m_tdata,
  input wire [bcpa_pkg::M_TUSER_W-1:0]  m_tuser
);
  import bcpa_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_inf_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata == '0) && (m_tuser[2:1] == STATUS_OK))
    else $error("infinity result with nonzero coordinates");

  a_bad_in: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:1] == STATUS_BAD_IN) |-> (m_tdata == '0) && !m_tuser[0])
    else $error("bad input result not cleared");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[2:1] != STATUS_UNUSED)
    else $error("unused status code");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind binary_curve_point_add bcpa_check u_bcpa_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
